// File: hdl/comb_splitter_fractional_delay_top_assert.svh
// Assertion macros used by the block's top-level RTL file.
`ifndef COMB_SPLITTER_FRACTIONAL_DELAY_TOP_ASSERT_SVH
`define COMB_SPLITTER_FRACTIONAL_DELAY_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define CSFD_ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define CSFD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define CSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define CSFD_ASSERT_ALWAYS(lbl, clk, rst, expr)
`define CSFD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define CSFD_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/csfd_pkg.sv
package csfd_pkg;

   localparam int LINE_DEPTH_DEF  = 16384;
   localparam int SAMPLE_BITS_DEF = 24;

   localparam int DELAY_W = 30;
   localparam int RAMP_W  = 13;
   localparam int FRAC_W  = 16;
   localparam int NUM_W   = DELAY_W + RAMP_W;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_DELAY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_LEN     = 2'd1;

   localparam logic [DELAY_W-1:0] TARGET_DELAY_RESET = 30'd65536000;
   localparam logic [DELAY_W-1:0] START_DELAY_RESET  = DELAY_W'(1000) << FRAC_W;
   localparam logic [RAMP_W-1:0]  RAMP_LEN_RESET     = 13'd1;

   typedef struct packed {
      logic               start;
      logic [NUM_W-1:0]   dividend;
      logic [RAMP_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DELAY_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: hdl/csfd_ram.sv
module csfd_ram #(
   parameter int WIDTH = csfd_pkg::SAMPLE_BITS_DEF,
   parameter int DEPTH = csfd_pkg::LINE_DEPTH_DEF,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              write_enable,
   input  logic [ADDR_W-1:0] write_addr,
   input  logic [WIDTH-1:0]  write_data,
   input  logic [ADDR_W-1:0] read_addr,
   output logic [WIDTH-1:0]  read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_addr] <= write_data;
      end
      read_data_ff <= mem_ff[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

// File: hdl/csfd_div.sv
module csfd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  csfd_pkg::div_req_type req,
   output csfd_pkg::div_rsp_type rsp
);

   import csfd_pkg::*;

   localparam int STEPS = DELAY_W / 2;
   localparam int CNT_W = $clog2(STEPS);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RAMP_W-1:0]  rem_ff, rem_in;
   logic [DELAY_W-1:0] quo_ff, quo_in;

   logic [RAMP_W:0]    den_ext;
   logic [RAMP_W:0]    t1, t2;
   logic [RAMP_W-1:0]  r1, r2;
   logic               q1, q2;

   // Two restoring steps a cycle; the quotient bits shift in where the
   // dividend bits shift out.
   always_comb begin
      den_ext = {1'b0, req.divisor};
      t1 = {rem_ff, quo_ff[DELAY_W-1]};
      q1 = (t1 >= den_ext);
      r1 = q1 ? RAMP_W'(t1 - den_ext) : t1[RAMP_W-1:0];
      t2 = {r1, quo_ff[DELAY_W-2]};
      q2 = (t2 >= den_ext);
      r2 = q2 ? RAMP_W'(t2 - den_ext) : t2[RAMP_W-1:0];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS - 1);
         rem_in  = req.dividend[NUM_W-1:DELAY_W];
         quo_in  = req.dividend[DELAY_W-1:0];
      end else if (busy_ff) begin
         rem_in = r2;
         quo_in = {quo_ff[DELAY_W-3:0], q1, q2};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// File: hdl/comb_splitter_fractional_delay_top.sv
// Comb splitter: each input word is set against a copy of the signal delayed by a
// fractional number of samples, read from a circular line with four-point Catmull-Rom
// interpolation, and half their sum and half their difference come out as one result
// word. The delay glides linearly to the target over the configured ramp length. A
// word is taken only while the block is idle, and each then passes in turn through
// the glide division, which yields two quotient bits a cycle, the reads of the line
// through the single read port of the memory, and the three interpolation products
// on the one shared multiplier. A finished result waits in the output register
// while the next word is already accepted. Entries of the line that have not yet
// been written read as zero through a fill count, so the block takes words straight
// after reset with no clearing pass.
`include "comb_splitter_fractional_delay_top_assert.svh"

module comb_splitter_fractional_delay_top #(
   parameter int LINE_DEPTH  = csfd_pkg::LINE_DEPTH_DEF,
   parameter int SAMPLE_BITS = csfd_pkg::SAMPLE_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [SAMPLE_BITS-1:0]       req_sample_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]       rsp_sum_out,
   output logic signed [SAMPLE_BITS-1:0]       rsp_diff_out,
   input  logic                                csr_write_enable,
   input  logic [csfd_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [csfd_pkg::DELAY_W-1:0]        csr_write_data
);

   import csfd_pkg::*;

   localparam int AW     = $clog2(LINE_DEPTH);
   localparam int FILL_W = AW + 1;
   localparam int PW     = AW + FRAC_W + 1;
   localparam int CMP_W  = (PW > DELAY_W) ? PW : DELAY_W;
   localparam int EW     = SAMPLE_BITS + 5;
   localparam int MW     = SAMPLE_BITS + 14;
   localparam int PRW    = MW + FRAC_W + 1;
   localparam int ACW    = SAMPLE_BITS + 23;

   localparam logic [PW-1:0]    SPAN      = PW'(LINE_DEPTH) << FRAC_W;
   localparam logic [CMP_W-1:0] MAX_DELAY = CMP_W'(LINE_DEPTH - 1) << FRAC_W;
   localparam logic signed [ACW-1:0] SAT_HI  = ACW'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [ACW-1:0] SAT_LO  = ~SAT_HI;
   localparam logic signed [ACW-1:0] ROUND_C = ACW'(1 << FRAC_W);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_MUL   = 4'd1;
   localparam logic [3:0] S_DIVGO = 4'd2;
   localparam logic [3:0] S_DIV   = 4'd3;
   localparam logic [3:0] S_ADDR  = 4'd4;
   localparam logic [3:0] S_READ  = 4'd5;
   localparam logic [3:0] S_WAIT  = 4'd6;
   localparam logic [3:0] S_COEF  = 4'd7;
   localparam logic [3:0] S_M1    = 4'd8;
   localparam logic [3:0] S_A1    = 4'd9;
   localparam logic [3:0] S_M2    = 4'd10;
   localparam logic [3:0] S_A2    = 4'd11;
   localparam logic [3:0] S_M3    = 4'd12;
   localparam logic [3:0] S_A3    = 4'd13;
   localparam logic [3:0] S_OUT   = 4'd14;

   function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] v);
      if (v == AW'(LINE_DEPTH - 1)) begin
         return '0;
      end
      return v + 1'b1;
   endfunction

   function automatic logic [AW-1:0] dec_wrap(input logic [AW-1:0] v);
      if (v == '0) begin
         return AW'(LINE_DEPTH - 1);
      end
      return v - 1'b1;
   endfunction

   function automatic logic [DELAY_W-1:0] clamp_delay(input logic [DELAY_W-1:0] v);
      if (CMP_W'(v) > MAX_DELAY) begin
         return DELAY_W'(MAX_DELAY);
      end
      return v;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] saturate(
      input logic signed [ACW-1:0] v);
      if (v > SAT_HI) begin
         return SAMPLE_BITS'(SAT_HI);
      end
      if (v < SAT_LO) begin
         return SAMPLE_BITS'(SAT_LO);
      end
      return SAMPLE_BITS'(v);
   endfunction

   logic [3:0]               state_ff, state_in;
   logic [DELAY_W-1:0]       target_ff, target_in;
   logic [RAMP_W-1:0]        ramp_len_ff, ramp_len_in;
   logic [DELAY_W-1:0]       start_delay_ff, start_delay_in;
   logic [RAMP_W-1:0]        ramp_count_ff, ramp_count_in;
   logic [AW-1:0]            wi_ff, wi_in;
   logic [FILL_W-1:0]        fill_ff, fill_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rd_vld_ff, rd_vld_in;
   logic [AW-1:0]            raddr_ff, raddr_in;
   logic [1:0]               rd_cnt_ff, rd_cnt_in;
   logic                     zok_ff, zok_in;

   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic [RAMP_W-1:0]        len_ff, len_in;
   logic [RAMP_W-1:0]        k_ff, k_in;
   logic [DELAY_W-1:0]       tgt_ff, tgt_in;
   logic [DELAY_W-1:0]       st_ff, st_in;
   logic [NUM_W-1:0]         na_ff, na_in;
   logic [NUM_W-1:0]         nb_ff, nb_in;
   logic [FRAC_W-1:0]        f_ff, f_in;
   logic signed [SAMPLE_BITS-1:0] ym1_ff, ym1_in, y0_ff, y0_in;
   logic signed [SAMPLE_BITS-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic signed [EW-1:0]     a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic signed [PRW-1:0]    prod_ff, prod_in;
   logic signed [ACW-1:0]    s_ff, s_in;
   logic signed [SAMPLE_BITS-1:0] sum_ff, sum_in, diff_ff, diff_in;

   logic [RAMP_W-1:0]        len_eff, k_acc, len_minus_k;
   logic [RAMP_W:0]          k_raw;
   logic [PW-1:0]            pos_sum, pos;
   logic [AW-1:0]            pos_idx;
   logic signed [MW-1:0]     mul_op;
   logic signed [FRAC_W:0]   f_ext;
   logic [SAMPLE_BITS-1:0]   rd_data;
   logic signed [SAMPLE_BITS-1:0] rd_data_eff;
   logic signed [ACW-1:0]    xs, acc_sum, acc_diff;
   logic                     out_go, mem_we;

   div_req_type div_req;
   div_rsp_type div_rsp;

   assign len_eff     = (ramp_len_ff == '0) ? RAMP_W'(1) : ramp_len_ff;
   assign k_raw       = {1'b0, ramp_count_ff} + 1'b1;
   assign k_acc       = (k_raw > {1'b0, len_eff}) ? len_eff : k_raw[RAMP_W-1:0];
   assign len_minus_k = len_ff - k_ff;

   assign pos_sum = PW'({wi_ff, {FRAC_W{1'b0}}}) + SPAN - PW'(div_rsp.quotient);
   assign pos     = (pos_sum >= SPAN) ? pos_sum - SPAN : pos_sum;
   assign pos_idx = pos[AW+FRAC_W-1:FRAC_W];

   assign mul_op      = (state_ff == S_M1) ? MW'(a_ff) : MW'(s_ff >>> 8);
   assign f_ext       = $signed({1'b0, f_ff});
   assign rd_data_eff = zok_ff ? $signed(rd_data) : '0;

   assign xs       = ACW'(x_ff) <<< FRAC_W;
   assign acc_sum  = xs + s_ff + ROUND_C;
   assign acc_diff = xs - s_ff + ROUND_C;

   assign out_go = !rsp_valid_ff || rsp_ready;
   assign mem_we = (state_ff == S_OUT) && out_go;

   assign div_req.start    = (state_ff == S_DIVGO);
   assign div_req.dividend = na_ff + nb_ff;
   assign div_req.divisor  = len_ff;

   always_comb begin
      state_in       = state_ff;
      target_in      = target_ff;
      ramp_len_in    = ramp_len_ff;
      start_delay_in = start_delay_ff;
      ramp_count_in  = ramp_count_ff;
      wi_in          = wi_ff;
      fill_in        = fill_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rd_vld_in      = 1'b0;
      raddr_in       = raddr_ff;
      rd_cnt_in      = rd_cnt_ff;
      zok_in         = zok_ff;
      x_in           = x_ff;
      len_in         = len_ff;
      k_in           = k_ff;
      tgt_in         = tgt_ff;
      st_in          = st_ff;
      na_in          = na_ff;
      nb_in          = nb_ff;
      f_in           = f_ff;
      a_in           = a_ff;
      b_in           = b_ff;
      c_in           = c_ff;
      prod_in        = prod_ff;
      s_in           = s_ff;
      sum_in         = sum_ff;
      diff_in        = diff_ff;
      ym1_in         = ym1_ff;
      y0_in          = y0_ff;
      y1_in          = y1_ff;
      y2_in          = y2_ff;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_TARGET_DELAY: target_in   = csr_write_data;
            CSR_RAMP_LEN:     ramp_len_in = csr_write_data[RAMP_W-1:0];
            default: ;
         endcase
      end

      // Line data arrives in the cycle after its address; the four taps shift in.
      if (rd_vld_ff) begin
         ym1_in = y0_ff;
         y0_in  = y1_ff;
         y1_in  = y2_ff;
         y2_in  = rd_data_eff;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               x_in     = req_sample_in;
               len_in   = len_eff;
               k_in     = k_acc;
               tgt_in   = clamp_delay(target_ff);
               st_in    = clamp_delay(start_delay_ff);
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            na_in    = st_ff * len_minus_k;
            nb_in    = tgt_ff * k_ff;
            state_in = S_DIVGO;
         end
         S_DIVGO: state_in = S_DIV;
         S_DIV: begin
            if (div_rsp.done) begin
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            raddr_in  = dec_wrap(pos_idx);
            f_in      = pos[FRAC_W-1:0];
            rd_cnt_in = '0;
            state_in  = S_READ;
         end
         S_READ: begin
            rd_vld_in = 1'b1;
            zok_in    = ({1'b0, raddr_ff} < fill_ff);
            raddr_in  = inc_wrap(raddr_ff);
            rd_cnt_in = rd_cnt_ff + 1'b1;
            if (rd_cnt_ff == 2'd3) begin
               state_in = S_WAIT;
            end
         end
         S_WAIT: state_in = S_COEF;
         S_COEF: begin
            a_in = EW'(3) * (EW'(y0_ff) - EW'(y1_ff)) - EW'(ym1_ff) + EW'(y2_ff);
            b_in = (EW'(y1_ff) <<< 2) + (EW'(ym1_ff) <<< 1) - EW'(5) * EW'(y0_ff)
                   - EW'(y2_ff);
            c_in = EW'(y1_ff) - EW'(ym1_ff);
            state_in = S_M1;
         end
         S_M1: begin
            prod_in  = mul_op * f_ext;
            state_in = S_A1;
         end
         S_A1: begin
            s_in     = (ACW'(b_ff) <<< FRAC_W) + ACW'(prod_ff);
            state_in = S_M2;
         end
         S_M2: begin
            prod_in  = mul_op * f_ext;
            state_in = S_A2;
         end
         S_A2: begin
            s_in     = (ACW'(c_ff) <<< FRAC_W) + ACW'(prod_ff >>> 8);
            state_in = S_M3;
         end
         S_M3: begin
            prod_in  = mul_op * f_ext;
            state_in = S_A3;
         end
         S_A3: begin
            s_in     = (ACW'(y0_ff) <<< FRAC_W) + ACW'(prod_ff >>> 9);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_go) begin
               sum_in       = saturate(acc_sum >>> (FRAC_W + 1));
               diff_in      = saturate(acc_diff >>> (FRAC_W + 1));
               rsp_valid_in = 1'b1;
               wi_in        = inc_wrap(wi_ff);
               if (fill_ff != FILL_W'(LINE_DEPTH)) begin
                  fill_in = fill_ff + 1'b1;
               end
               if (k_ff >= len_ff) begin
                  start_delay_in = tgt_ff;
                  ramp_count_in  = '0;
               end else begin
                  ramp_count_in = k_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         target_ff      <= TARGET_DELAY_RESET;
         ramp_len_ff    <= RAMP_LEN_RESET;
         start_delay_ff <= START_DELAY_RESET;
         ramp_count_ff  <= '0;
         wi_ff          <= '0;
         fill_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         rd_vld_ff      <= 1'b0;
         raddr_ff       <= '0;
         rd_cnt_ff      <= '0;
         zok_ff         <= 1'b0;
      end else begin
         state_ff       <= state_in;
         target_ff      <= target_in;
         ramp_len_ff    <= ramp_len_in;
         start_delay_ff <= start_delay_in;
         ramp_count_ff  <= ramp_count_in;
         wi_ff          <= wi_in;
         fill_ff        <= fill_in;
         rsp_valid_ff   <= rsp_valid_in;
         rd_vld_ff      <= rd_vld_in;
         raddr_ff       <= raddr_in;
         rd_cnt_ff      <= rd_cnt_in;
         zok_ff         <= zok_in;
      end
      x_ff    <= x_in;
      len_ff  <= len_in;
      k_ff    <= k_in;
      tgt_ff  <= tgt_in;
      st_ff   <= st_in;
      na_ff   <= na_in;
      nb_ff   <= nb_in;
      f_ff    <= f_in;
      ym1_ff  <= ym1_in;
      y0_ff   <= y0_in;
      y1_ff   <= y1_in;
      y2_ff   <= y2_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      c_ff    <= c_in;
      prod_ff <= prod_in;
      s_ff    <= s_in;
      sum_ff  <= sum_in;
      diff_ff <= diff_in;
   end

   csfd_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (LINE_DEPTH)
   ) u_line (
      .clock        (clock),
      .write_enable (mem_we),
      .write_addr   (wi_ff),
      .write_data   (x_ff),
      .read_addr    (raddr_ff),
      .read_data    (rd_data)
   );

   csfd_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ready    = (state_ff == S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_sum_out  = sum_ff;
   assign rsp_diff_out = diff_ff;

   `CSFD_ASSERT_ALWAYS(a_raddr_range, clock, reset, raddr_ff <= AW'(LINE_DEPTH - 1))
   `CSFD_ASSERT_ALWAYS(a_fill_tracks_index, clock, reset, (fill_ff == FILL_W'(LINE_DEPTH)) || (fill_ff == FILL_W'(wi_ff)))
   `CSFD_ASSERT_NEXT(a_write_advances, clock, reset, mem_we, wi_ff != $past(wi_ff))
   `CSFD_ASSERT_IMPLIES(a_divisor_nonzero, clock, reset, state_ff == S_DIVGO, len_ff != '0)

endmodule
